// ===== rtl/bnr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnr_pkg
// Shared widths, register indexes and types of the Bezier Newton step.
// ----------------------------------------------------------------------------
package bnr_pkg;

   localparam int CW     = 42;          // internal coordinate width
   localparam int UW     = 32;          // parameter width
   localparam int UFRAC  = 30;          // fraction bits of u
   localparam int SPLIT  = 21;          // partial product split point
   localparam int PW     = 88;          // dot product width
   localparam int MW     = PW - 1;      // magnitude width
   localparam int QW     = 41;          // quotient bits, cap is 2^(QW-1)
   localparam int NFRONT = 13;          // stages ahead of the divider
   localparam int IDXW   = 3;
   localparam int DATW   = 64;

   localparam logic [IDXW-1:0] CSR_CP0    = 3'd0;
   localparam logic [IDXW-1:0] CSR_CP1    = 3'd1;
   localparam logic [IDXW-1:0] CSR_CP2    = 3'd2;
   localparam logic [IDXW-1:0] CSR_CP3    = 3'd3;
   localparam logic [IDXW-1:0] CSR_DEGREE = 3'd4;

   localparam logic [1:0] DEG_QUAD  = 2'd2;
   localparam logic [1:0] DEG_CUBIC = 2'd3;

   typedef logic signed [CW-1:0] coord_type;
   // [set: curve, first diff, second diff][point][x, y]
   typedef coord_type cset_type [0:2][0:3][0:1];

   typedef struct packed {
      logic               vld;
      logic signed [31:0] u;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic               last;
   } side_type;

   typedef struct packed {
      logic               vld;
      logic signed [31:0] u;
      logic               last;
      logic               neg;
      logic               zero;
   } div_side_type;

endpackage

// ===== rtl/bnr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnr_if
// Channel interfaces: point requests, refined parameters, register writes.
// ----------------------------------------------------------------------------
interface bnr_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] param_u;
   logic               last_point;
   modport source (output valid, point_x, point_y, param_u, last_point, input ready);
   modport sink   (input valid, point_x, point_y, param_u, last_point, output ready);
endinterface

interface bnr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] new_u;
   logic               kept_unchanged;
   logic               saturated;
   logic               last_point_out;
   modport source (output valid, new_u, kept_unchanged, saturated, last_point_out,
                   input ready);
   modport sink   (input valid, new_u, kept_unchanged, saturated, last_point_out,
                   output ready);
endinterface

interface bnr_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/bnr_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnr_csr
// Control point registers, degree, and the registered start polygons.
// ----------------------------------------------------------------------------
module bnr_csr (
   input  logic               clock,
   input  logic               reset,
   bnr_csr_if.sink            csr_bus,
   output bnr_pkg::cset_type  start,
   output logic               cubic
);

   logic [bnr_pkg::DATW-1:0] cp_ff [0:3];
   logic [1:0]               degree_ff;
   bnr_pkg::coord_type       pt    [0:3][0:1];
   bnr_pkg::coord_type       d1    [0:2][0:1];
   bnr_pkg::coord_type       d2    [0:1][0:1];
   bnr_pkg::coord_type       df1   [0:2][0:1];
   bnr_pkg::coord_type       df2   [0:1][0:1];
   bnr_pkg::cset_type        start_ff;

   assign csr_bus.ready = 1'b1;
   assign cubic         = (degree_ff != bnr_pkg::DEG_QUAD);
   assign start         = start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) cp_ff[i] <= '0;
         degree_ff <= bnr_pkg::DEG_CUBIC;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            bnr_pkg::CSR_CP0:    cp_ff[0]  <= csr_bus.data;
            bnr_pkg::CSR_CP1:    cp_ff[1]  <= csr_bus.data;
            bnr_pkg::CSR_CP2:    cp_ff[2]  <= csr_bus.data;
            bnr_pkg::CSR_CP3:    cp_ff[3]  <= csr_bus.data;
            bnr_pkg::CSR_DEGREE: degree_ff <= csr_bus.data[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         pt[i][0] = bnr_pkg::CW'($signed(cp_ff[i][63:32]));
         pt[i][1] = bnr_pkg::CW'($signed(cp_ff[i][31:0]));
      end
      for (int i = 0; i < 3; i++) begin
         for (int c = 0; c < 2; c++) begin
            df1[i][c] = pt[i+1][c] - pt[i][c];
            d1[i][c]  = cubic ? (df1[i][c] <<< 1) + df1[i][c] : (df1[i][c] <<< 1);
         end
      end
      for (int i = 0; i < 2; i++) begin
         for (int c = 0; c < 2; c++) begin
            df2[i][c] = d1[i+1][c] - d1[i][c];
            d2[i][c]  = cubic ? (df2[i][c] <<< 1) : df2[i][c];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 2; c++) begin
         for (int i = 0; i < 4; i++) start_ff[0][i][c] <= pt[i][c];
         for (int i = 0; i < 3; i++) start_ff[1][i][c] <= d1[i][c];
         start_ff[1][3][c] <= '0;
         for (int i = 0; i < 2; i++) start_ff[2][i][c] <= d2[i][c];
         start_ff[2][2][c] <= '0;
         start_ff[2][3][c] <= '0;
      end
   end

endmodule

// ===== rtl/bnr_lerp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnr_lerp
// One de Casteljau step a + floor((b - a) * u / 2^30) over two stages.
// ----------------------------------------------------------------------------
module bnr_lerp (
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [31:0]        u,
   input  bnr_pkg::coord_type        a,
   input  bnr_pkg::coord_type        b,
   input  logic                      bypass,
   output bnr_pkg::coord_type        y
);

   localparam int HW  = bnr_pkg::CW - bnr_pkg::SPLIT;
   localparam int PHW = HW + bnr_pkg::UW;
   localparam int PLW = bnr_pkg::SPLIT + 1 + bnr_pkg::UW;
   localparam int PRW = bnr_pkg::CW + bnr_pkg::UW;

   bnr_pkg::coord_type        diff;
   logic signed [HW-1:0]      hi;
   logic signed [bnr_pkg::SPLIT:0] lo;
   logic signed [PHW-1:0]     ph_ff;
   logic signed [PLW-1:0]     pl_ff;
   bnr_pkg::coord_type        a_ff;
   logic                      byp_ff;
   logic signed [PRW-1:0]     prod;
   logic signed [PRW-1:0]     sh;
   bnr_pkg::coord_type        y_ff;

   assign diff = b - a;
   assign hi   = diff[bnr_pkg::CW-1:bnr_pkg::SPLIT];
   assign lo   = $signed({1'b0, diff[bnr_pkg::SPLIT-1:0]});

   always_ff @(posedge clock) begin
      if (en) begin
         ph_ff  <= hi * u;
         pl_ff  <= lo * u;
         a_ff   <= a;
         byp_ff <= bypass;
      end
   end

   assign prod = (PRW'(ph_ff) <<< bnr_pkg::SPLIT) + PRW'(pl_ff);
   assign sh   = prod >>> bnr_pkg::UFRAC;

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff <= byp_ff ? a_ff : $signed(a_ff + sh[bnr_pkg::CW-1:0]);
      end
   end

   assign y = y_ff;

endmodule

// ===== rtl/bnr_product.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnr_product
// Signed coordinate product from four registered partial products.
// ----------------------------------------------------------------------------
module bnr_product (
   input  logic                          clock,
   input  logic                          en,
   input  bnr_pkg::coord_type            a,
   input  bnr_pkg::coord_type            b,
   output logic signed [bnr_pkg::PW-1:0] p
);

   localparam int HW = bnr_pkg::CW - bnr_pkg::SPLIT;
   localparam int LW = bnr_pkg::SPLIT + 1;

   logic signed [HW-1:0]      ah, bh;
   logic signed [LW-1:0]      al, bl;
   logic signed [2*HW-1:0]    hh_ff;
   logic signed [HW+LW-1:0]   hl_ff, lh_ff;
   logic signed [2*LW-1:0]    ll_ff;
   logic signed [bnr_pkg::PW-1:0] p_ff;

   assign ah = a[bnr_pkg::CW-1:bnr_pkg::SPLIT];
   assign bh = b[bnr_pkg::CW-1:bnr_pkg::SPLIT];
   assign al = $signed({1'b0, a[bnr_pkg::SPLIT-1:0]});
   assign bl = $signed({1'b0, b[bnr_pkg::SPLIT-1:0]});

   always_ff @(posedge clock) begin
      if (en) begin
         hh_ff <= ah * bh;
         hl_ff <= ah * bl;
         lh_ff <= al * bh;
         ll_ff <= al * bl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= (bnr_pkg::PW'(hh_ff) <<< (2 * bnr_pkg::SPLIT))
               + ((bnr_pkg::PW'(hl_ff) + bnr_pkg::PW'(lh_ff)) <<< bnr_pkg::SPLIT)
               + bnr_pkg::PW'(ll_ff);
      end
   end

   assign p = p_ff;

endmodule

// ===== rtl/bnr_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnr_divider
// Pipelined restoring divider, n * 2^30 / d, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bnr_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic [bnr_pkg::MW-1:0]       n,
   input  logic [bnr_pkg::MW-1:0]       d,
   input  bnr_pkg::div_side_type        side_i,
   output logic [bnr_pkg::QW-1:0]       q,
   output logic                         ovf,
   output bnr_pkg::div_side_type        side_o
);

   localparam int SH = bnr_pkg::QW - bnr_pkg::UFRAC;
   localparam int QW = bnr_pkg::QW;
   localparam int MW = bnr_pkg::MW;

   logic [MW-1:0]         rem_ff  [0:QW];
   logic [QW-1:0]         q_ff    [0:QW];
   logic [QW-1:0]         bits_ff [0:QW];
   logic [MW-1:0]         d_ff    [0:QW];
   logic                  ovf_ff  [0:QW];
   bnr_pkg::div_side_type side_ff [0:QW];
   logic [MW-1:0]         top_n;

   assign top_n = n >> SH;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff[0] <= '0;
      end else if (en) begin
         side_ff[0] <= side_i;
         rem_ff[0]  <= top_n;
         ovf_ff[0]  <= (top_n >= d);
         bits_ff[0] <= {n[SH-1:0], {bnr_pkg::UFRAC{1'b0}}};
         q_ff[0]    <= '0;
         d_ff[0]    <= d;
      end
   end

   for (genvar k = 1; k <= QW; k++) begin : g_step
      logic [MW:0] remx;
      logic [MW:0] sub;
      logic        ge;

      assign remx = {rem_ff[k-1], bits_ff[k-1][QW-1]};
      assign ge   = (remx >= {1'b0, d_ff[k-1]});
      assign sub  = remx - {1'b0, d_ff[k-1]};

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[k] <= '0;
         end else if (en) begin
            side_ff[k] <= side_ff[k-1];
            rem_ff[k]  <= ge ? sub[MW-1:0] : remx[MW-1:0];
            q_ff[k]    <= {q_ff[k-1][QW-2:0], ge};
            bits_ff[k] <= bits_ff[k-1] << 1;
            d_ff[k]    <= d_ff[k-1];
            ovf_ff[k]  <= ovf_ff[k-1];
         end
      end
   end

   assign q      = q_ff[QW];
   assign ovf    = ovf_ff[QW];
   assign side_o = side_ff[QW];

endmodule

// ===== rtl/bezier_newton_reparameterize.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_newton_reparameterize
// One Newton step of a point's parameter toward the closest curve point.
//
//   channel   dir  beat
//   req_bus   in   point_x, point_y, param_u, last_point
//   rsp_bus   out  new_u, kept_unchanged, saturated, last_point_out
//   csr_bus   in   index, data (control points 0..3, degree)
//
// One beat per cycle unless a response waits on rsp_bus.ready; the divider
// resolves one quotient bit per stage. Reset clears the pipeline and returns
// the control points to zero and the degree to cubic. While a response
// waits on rsp_bus.ready the whole pipeline holds.
// ----------------------------------------------------------------------------
module bezier_newton_reparameterize (
   input  logic      clock,
   input  logic      reset,
   bnr_req_if.sink   req_bus,
   bnr_rsp_if.source rsp_bus,
   bnr_csr_if.sink   csr_bus
);

   localparam int NF  = bnr_pkg::NFRONT;
   localparam int PW  = bnr_pkg::PW;
   localparam int MW  = bnr_pkg::MW;
   localparam int QW  = bnr_pkg::QW;
   localparam int NUW = QW + 2;

   localparam logic [QW-1:0]         QCAP   = QW'(1) << (QW - 1);
   localparam logic signed [NUW-1:0] NU_MAX = NUW'(32'sh7fff_ffff);
   localparam logic signed [NUW-1:0] NU_MIN = ~NU_MAX;

   logic                  adv;
   bnr_pkg::cset_type     start;
   logic                  cubic;
   bnr_pkg::side_type     side_ff [0:NF-1];
   logic [NF-1:0]         front_vld;
   bnr_pkg::coord_type    lv [0:3][0:2][0:3][0:1];

   bnr_pkg::coord_type    dx_ff, dy_ff;
   bnr_pkg::coord_type    q1_ff [0:1];
   bnr_pkg::coord_type    q2_ff [0:1];
   bnr_pkg::coord_type    pa [0:5];
   bnr_pkg::coord_type    pb [0:5];
   logic signed [PW-1:0]  pr [0:5];
   logic signed [PW-1:0]  num_ff, sa_ff, sb_ff, numb_ff, den_ff;
   logic signed [PW-1:0]  nabs, dabs;
   logic [MW-1:0]         an_ff, ad_ff;
   logic                  neg_ff, zero_ff;
   bnr_pkg::div_side_type dv_in, dv_side;
   logic [QW-1:0]         dv_q;
   logic                  dv_ovf;

   logic [QW-1:0]         qc;
   logic signed [NUW-1:0] ue, qe, nu;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic signed [31:0]    new_u_ff, new_u_in;
   logic                  kept_ff, kept_in, sat_ff, sat_in, last_ff, last_in;

   assign adv           = !rsp_vld_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   bnr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .start   (start),
      .cubic   (cubic)
   );

   // sideband pipe ahead of the divider
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NF; i++) side_ff[i] <= '0;
      end else if (adv) begin
         side_ff[0] <= '{vld: req_bus.valid, u: req_bus.param_u, px: req_bus.point_x,
                         py: req_bus.point_y, last: req_bus.last_point};
         for (int i = 1; i < NF; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   always_comb begin
      for (int i = 0; i < NF; i++) front_vld[i] = side_ff[i].vld;
   end

   // three de Casteljau levels over curve, first and second difference polygons
   for (genvar s = 0; s < 3; s++) begin : g_set0
      for (genvar j = 0; j < 4; j++) begin : g_pt0
         for (genvar c = 0; c < 2; c++) begin : g_c0
            assign lv[0][s][j][c] = start[s][j][c];
         end
      end
   end

   for (genvar L = 1; L <= 3; L++) begin : g_lvl
      for (genvar s = 0; s < 3; s++) begin : g_set
         for (genvar j = 0; j < 4; j++) begin : g_pt
            for (genvar c = 0; c < 2; c++) begin : g_c
               if ((j <= 3 - L) && (L > s)) begin : g_act
                  bnr_lerp u_lerp (
                     .clock  (clock),
                     .en     (adv),
                     .u      (side_ff[2*L-2].u),
                     .a      (lv[L-1][s][j][c]),
                     .b      (lv[L-1][s][j+1][c]),
                     .bypass ((L > s + 1) ? 1'b0 : !cubic),
                     .y      (lv[L][s][j][c])
                  );
               end else begin : g_pass
                  bnr_lerp u_lerp (
                     .clock  (clock),
                     .en     (adv),
                     .u      (side_ff[2*L-2].u),
                     .a      (lv[L-1][s][j][c]),
                     .b      (lv[L-1][s][j][c]),
                     .bypass (1'b1),
                     .y      (lv[L][s][j][c])
                  );
               end
            end
         end
      end
   end

   // Q - P, Q', Q''
   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff    <= lv[3][0][0][0] - bnr_pkg::CW'(side_ff[6].px);
         dy_ff    <= lv[3][0][0][1] - bnr_pkg::CW'(side_ff[6].py);
         q1_ff[0] <= lv[3][1][0][0];
         q1_ff[1] <= lv[3][1][0][1];
         q2_ff[0] <= lv[3][2][0][0];
         q2_ff[1] <= lv[3][2][0][1];
      end
   end

   always_comb begin
      pa[0] = dx_ff;    pb[0] = q1_ff[0];
      pa[1] = dy_ff;    pb[1] = q1_ff[1];
      pa[2] = q1_ff[0]; pb[2] = q1_ff[0];
      pa[3] = q1_ff[1]; pb[3] = q1_ff[1];
      pa[4] = dx_ff;    pb[4] = q2_ff[0];
      pa[5] = dy_ff;    pb[5] = q2_ff[1];
   end

   for (genvar k = 0; k < 6; k++) begin : g_prod
      bnr_product u_prod (
         .clock (clock),
         .en    (adv),
         .a     (pa[k]),
         .b     (pb[k]),
         .p     (pr[k])
      );
   end

   assign nabs = numb_ff[PW-1] ? -numb_ff : numb_ff;
   assign dabs = den_ff[PW-1] ? -den_ff : den_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff  <= pr[0] + pr[1];
         sa_ff   <= pr[2] + pr[3];
         sb_ff   <= pr[4] + pr[5];
         numb_ff <= num_ff;
         den_ff  <= sa_ff + sb_ff;
         an_ff   <= nabs[MW-1:0];
         ad_ff   <= dabs[MW-1:0];
         neg_ff  <= numb_ff[PW-1] ^ den_ff[PW-1];
         zero_ff <= (den_ff == '0);
      end
   end

   assign dv_in = '{vld: side_ff[NF-1].vld, u: side_ff[NF-1].u, last: side_ff[NF-1].last,
                    neg: neg_ff, zero: zero_ff};

   bnr_divider u_div (
      .clock  (clock),
      .reset  (reset),
      .en     (adv),
      .n      (an_ff),
      .d      (ad_ff),
      .side_i (dv_in),
      .q      (dv_q),
      .ovf    (dv_ovf),
      .side_o (dv_side)
   );

   // cap, apply sign, saturate
   assign qc = (dv_ovf || dv_q[QW-1]) ? QCAP : dv_q;
   assign ue = NUW'(dv_side.u);
   assign qe = $signed({2'b00, qc});
   assign nu = dv_side.neg ? ue + qe : ue - qe;

   always_comb begin
      rsp_vld_in = dv_side.vld;
      last_in    = dv_side.last;
      kept_in    = dv_side.zero;
      sat_in     = 1'b0;
      new_u_in   = dv_side.u;
      if (!dv_side.zero) begin
         if (nu > NU_MAX) begin
            sat_in   = 1'b1;
            new_u_in = NU_MAX[31:0];
         end else if (nu < NU_MIN) begin
            sat_in   = 1'b1;
            new_u_in = NU_MIN[31:0];
         end else begin
            new_u_in = nu[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         new_u_ff <= new_u_in;
         kept_ff  <= kept_in;
         sat_ff   <= sat_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_bus.valid          = rsp_vld_ff;
   assign rsp_bus.new_u          = new_u_ff;
   assign rsp_bus.kept_unchanged = kept_ff;
   assign rsp_bus.saturated      = sat_ff;
   assign rsp_bus.last_point_out = last_ff;

`ifndef SYNTHESIS
   a_sat_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.saturated) |->
      (rsp_bus.new_u == 32'h7fff_ffff || rsp_bus.new_u == 32'h8000_0000))
      else $error("saturated beat not at a range end");

   a_kept_nosat: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.kept_unchanged) |-> !rsp_bus.saturated)
      else $error("pass-through beat flagged saturated");

   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> (front_vld == $past(front_vld)))
      else $error("front pipeline moved during stall");

   a_zero_den: assert property (@(posedge clock) disable iff (reset)
      (adv && dv_side.vld && dv_side.zero) |=> (rsp_bus.valid && rsp_bus.kept_unchanged))
      else $error("zero denominator not passed through");

   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_bus.valid |-> req_bus.ready)
      else $error("request stalled with empty output");
`endif

endmodule

// ===== tb/sv/bnr_step_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnr_step_checker
// Watches the point, response and register channels of the Bezier Newton
// step. Keeps its own copy of the control points and degree, predicts the
// refined parameter of every accepted point beat, and compares the response
// beats in order against the oldest prediction.
// ----------------------------------------------------------------------------
module bnr_step_checker (
   input  logic clock,
   input  logic reset,
   bnr_req_if   req_bus,
   bnr_rsp_if   rsp_bus,
   bnr_csr_if   csr_bus,
   output int   fail_count,
   output int   steps_pending,
   output int   kept_seen,
   output int   sat_seen
);

   typedef struct {
      logic signed [31:0] new_u;
      logic               kept;
      logic               sat;
      logic               last;
   } step_result_type;

   logic [63:0]     ctrl_pt [0:3];
   logic [1:0]      degree;
   step_result_type expected_steps [$];

   function automatic logic signed [127:0] wide_mul(input longint a, input longint b);
      logic signed [127:0] a128, b128;
      a128 = a;
      b128 = b;
      return a128 * b128;
   endfunction

   // a + floor((b - a) * t / 2^30)
   function automatic longint lerp_u(input longint a, input longint b, input longint t);
      logic signed [127:0] m;
      m = wide_mul(b - a, t);
      m = m >>> bnr_pkg::UFRAC;
      return a + longint'(m);
   endfunction

   function automatic void casteljau(input longint pts [0:3][0:1], input int deg,
                                     input longint t, output longint rx,
                                     output longint ry);
      longint w [0:3][0:1];
      w = pts;
      for (int i = 1; i <= deg; i++)
         for (int j = 0; j <= deg - i; j++)
            for (int c = 0; c < 2; c++)
               w[j][c] = lerp_u(w[j][c], w[j+1][c], t);
      rx = w[0][0];
      ry = w[0][1];
   endfunction

   function automatic step_result_type newton_step_predict(
         input logic signed [31:0] px, input logic signed [31:0] py,
         input logic signed [31:0] u, input logic last);
      step_result_type r;
      int deg;
      longint p  [0:3][0:1];
      longint d1 [0:3][0:1];
      longint d2 [0:3][0:1];
      longint q0x, q0y, q1x, q1y, q2x, q2y, dx, dy, q, nu;
      logic signed [127:0] num, den;
      logic [159:0] an, ad, qq;
      deg = (degree == bnr_pkg::DEG_QUAD) ? 2 : 3;
      for (int i = 0; i < 4; i++) begin
         p[i][0] = longint'($signed(ctrl_pt[i][63:32]));
         p[i][1] = longint'($signed(ctrl_pt[i][31:0]));
         for (int c = 0; c < 2; c++) begin
            d1[i][c] = 0;
            d2[i][c] = 0;
         end
      end
      for (int i = 0; i < deg; i++)
         for (int c = 0; c < 2; c++)
            d1[i][c] = deg * (p[i+1][c] - p[i][c]);
      for (int i = 0; i < deg - 1; i++)
         for (int c = 0; c < 2; c++)
            d2[i][c] = (deg - 1) * (d1[i+1][c] - d1[i][c]);
      casteljau(p, deg, u, q0x, q0y);
      casteljau(d1, deg - 1, u, q1x, q1y);
      casteljau(d2, deg - 2, u, q2x, q2y);
      dx  = q0x - px;
      dy  = q0y - py;
      num = wide_mul(dx, q1x) + wide_mul(dy, q1y);
      den = wide_mul(q1x, q1x) + wide_mul(q1y, q1y) + wide_mul(dx, q2x)
            + wide_mul(dy, q2y);
      r.kept = 1'b0;
      r.sat  = 1'b0;
      r.last = last;
      r.new_u = u;
      if (den == 0) begin
         r.kept = 1'b1;
      end else begin
         an = num[127] ? 160'(-num) : 160'(num);
         ad = den[127] ? 160'(-den) : 160'(den);
         qq = (an << bnr_pkg::UFRAC) / ad;
         if (qq > (160'(1) << 40)) qq = 160'(1) << 40;
         q  = longint'(qq[63:0]);
         nu = longint'(u) - ((num[127] ^ den[127]) ? -q : q);
         if (nu > 64'sd2147483647) begin
            nu = 64'sd2147483647;
            r.sat = 1'b1;
         end else if (nu < -64'sd2147483648) begin
            nu = -64'sd2147483648;
            r.sat = 1'b1;
         end
         r.new_u = nu[31:0];
      end
      return r;
   endfunction

   assign steps_pending = expected_steps.size();

   always @(posedge clock) begin
      step_result_type want;
      step_result_type fresh;
      if (reset) begin
         for (int i = 0; i < 4; i++) ctrl_pt[i] <= '0;
         degree <= bnr_pkg::DEG_CUBIC;
         expected_steps.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               bnr_pkg::CSR_CP0, bnr_pkg::CSR_CP1, bnr_pkg::CSR_CP2, bnr_pkg::CSR_CP3:
                  ctrl_pt[csr_bus.index[1:0]] <= csr_bus.data;
               bnr_pkg::CSR_DEGREE: degree <= csr_bus.data[1:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            fresh = newton_step_predict(req_bus.point_x, req_bus.point_y,
                                        req_bus.param_u, req_bus.last_point);
            expected_steps = {expected_steps, fresh};
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_steps.size() == 0) begin
               $error("unexpected response beat: new_u %h", rsp_bus.new_u);
               fail_count++;
            end else begin
               want = expected_steps.pop_front();
               if (want.kept) kept_seen++;
               if (want.sat) sat_seen++;
               if (rsp_bus.new_u !== want.new_u) begin
                  $error("new_u: expected %h, got %h", want.new_u, rsp_bus.new_u);
                  fail_count++;
               end
               if (rsp_bus.kept_unchanged !== want.kept) begin
                  $error("kept_unchanged: expected %b, got %b", want.kept,
                         rsp_bus.kept_unchanged);
                  fail_count++;
               end
               if (rsp_bus.saturated !== want.sat) begin
                  $error("saturated: expected %b, got %b", want.sat, rsp_bus.saturated);
                  fail_count++;
               end
               if (rsp_bus.last_point_out !== want.last) begin
                  $error("last_point_out: expected %b, got %b", want.last,
                         rsp_bus.last_point_out);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      fail_count = 0;
      kept_seen  = 0;
      sat_seen   = 0;
   end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the Bezier Newton step: directed points on a few fixed
// curves, then phases of random curves and points with random gaps and
// back-pressure, register writes only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int DRAIN = 80;
   localparam logic [31:0] ONE16 = 32'h0001_0000;
   localparam logic [31:0] U_ONE = 32'h4000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, steps_pending, kept_seen, sat_seen;
   int   points_sent = 0;
   int   stall_order = 0;
   int   stall_left  = 0;
   bit   quiet = 1'b0;

   bnr_req_if req_bus ();
   bnr_rsp_if rsp_bus ();
   bnr_csr_if csr_bus ();

   bezier_newton_reparameterize i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   bnr_step_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .csr_bus       (csr_bus),
      .fail_count    (fail_count),
      .steps_pending (steps_pending),
      .kept_seen     (kept_seen),
      .sat_seen      (sat_seen)
   );

   always #5 clock = ~clock;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // response side: random stalls, plus long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_order > 0) begin
         stall_left  = stall_order;
         stall_order = 0;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 20) begin
         stall_left = gap_len();
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic csr_write(input logic [bnr_pkg::IDXW-1:0] idx, input logic [63:0] data);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic send_point(input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] u, input logic last);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.point_x    <= px;
      req_bus.point_y    <= py;
      req_bus.param_u    <= u;
      req_bus.last_point <= last;
      do @(posedge clock); while (!req_bus.ready);
      points_sent++;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (steps_pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic set_curve(input logic [63:0] a, input logic [63:0] b,
                            input logic [63:0] c, input logic [63:0] d,
                            input logic [1:0] deg);
      csr_write(bnr_pkg::CSR_CP0, a);
      csr_write(bnr_pkg::CSR_CP1, b);
      csr_write(bnr_pkg::CSR_CP2, c);
      csr_write(bnr_pkg::CSR_CP3, d);
      csr_write(bnr_pkg::CSR_DEGREE, {62'd0, deg});
   endtask

   function automatic logic [31:0] rand_coord(input int span);
      if (span == 0) return $urandom();
      return $signed($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic logic [31:0] rand_u();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return $urandom_range(0, U_ONE);
      if (r < 9) return $signed($urandom_range(0, 3 * U_ONE / 2)) - U_ONE / 4;
      return $urandom();
   endfunction

   task automatic random_phase(input int n_items, input int span);
      logic [63:0] cp [0:3];
      logic [1:0]  deg;
      for (int i = 0; i < 4; i++) cp[i] = {rand_coord(span), rand_coord(span)};
      deg = ($urandom_range(0, 5) == 0) ? 2'($urandom_range(0, 1))
            : ($urandom_range(0, 1) ? bnr_pkg::DEG_QUAD : bnr_pkg::DEG_CUBIC);
      set_curve(cp[0], cp[1], cp[2], cp[3], deg);
      if ($urandom_range(0, 3) == 0)
         csr_write(bnr_pkg::IDXW'($urandom_range(5, 7)), {$urandom(), $urandom()});
      for (int k = 0; k < n_items; k++) begin
         if ($urandom_range(0, 3) == 0)
            send_point(rand_coord(0), rand_coord(0), rand_u(), $urandom_range(0, 1));
         else
            send_point(rand_coord(span == 0 ? 32'h7fff_ffff : span),
                       rand_coord(span == 0 ? 32'h7fff_ffff : span),
                       rand_u(), k == n_items - 1);
      end
      drain();
   endtask

   initial begin
      int spans [0:3];
      spans = '{0, 32'h0010_0000, 32'h0400_0000, 32'h0000_4000};
      req_bus.valid      <= 1'b0;
      req_bus.point_x    <= '0;
      req_bus.point_y    <= '0;
      req_bus.param_u    <= '0;
      req_bus.last_point <= 1'b0;
      csr_bus.valid      <= 1'b0;
      csr_bus.index      <= bnr_pkg::CSR_CP0;
      csr_bus.data       <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset curve is all zero: denominator vanishes
      send_point(32'h1234_5678, 32'h8000_0000, U_ONE / 2, 1'b0);
      send_point(32'h7fff_ffff, 32'h0, 32'h7fff_ffff, 1'b1);
      drain();

      set_curve({32'h0, 32'h0}, {ONE16, 2 * ONE16}, {3 * ONE16, 2 * ONE16},
                {4 * ONE16, 32'h0}, bnr_pkg::DEG_CUBIC);
      send_point(ONE16, ONE16, 32'h0, 1'b0);
      send_point(2 * ONE16, 3 * ONE16, U_ONE, 1'b0);
      send_point(2 * ONE16, 32'h0, U_ONE / 2, 1'b0);
      send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
      send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
      send_point(5 * ONE16, -ONE16, 32'hf000_0000, 1'b0);
      drain();

      set_curve({32'h0, 32'h0}, {ONE16, 2 * ONE16}, {2 * ONE16, 32'h0},
                {32'hffff_ffff, 32'hffff_ffff}, bnr_pkg::DEG_QUAD);
      send_point(ONE16, ONE16, U_ONE / 3, 1'b0);
      send_point(ONE16, 32'h0, U_ONE / 2, 1'b1);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
      send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
      drain();

      set_curve({32'h8000_0000, 32'h7fff_ffff}, {32'h7fff_ffff, 32'h8000_0000},
                {32'h8000_0000, 32'h8000_0000}, {32'h7fff_ffff, 32'h7fff_ffff}, 2'd0);
      send_point(32'h0, 32'h0, U_ONE / 2, 1'b0);
      send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
      send_point(32'h8000_0000, 32'h0, 32'h8000_0000, 1'b0);
      drain();

      // straight line: flat second derivative
      set_curve({32'h0, 32'h0}, {ONE16, ONE16}, {2 * ONE16, 2 * ONE16},
                {3 * ONE16, 3 * ONE16}, 2'd1);
      csr_write(3'd7, '1);
      send_point(ONE16, 2 * ONE16, U_ONE / 4, 1'b0);
      send_point(32'h7fff_ffff, 32'h0, 32'h0, 1'b1);
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         quiet = (ph == 3);
         random_phase(45, spans[ph % 4]);
      end
      quiet = 1'b0;

      // long receiver hold-off while points keep coming
      stall_order = 300;
      quiet = 1'b1;
      set_curve({rand_coord(32'h0010_0000), rand_coord(32'h0010_0000)},
                {rand_coord(32'h0010_0000), rand_coord(32'h0010_0000)},
                {rand_coord(32'h0010_0000), rand_coord(32'h0010_0000)},
                {rand_coord(32'h0010_0000), rand_coord(32'h0010_0000)},
                bnr_pkg::DEG_CUBIC);
      for (int k = 0; k < 80; k++)
         send_point(rand_coord(32'h0010_0000), rand_coord(32'h0010_0000), rand_u(), k[0]);
      quiet = 1'b0;
      drain();

      $display("Sent %0d point beats over 16 curve settings, both degrees and the unused",
               points_sent);
      $display("degree codes; %0d responses kept u and %0d saturated.", kept_seen, sat_seen);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== bezier_newton_reparameterize.f =====
rtl/bnr_pkg.sv
rtl/bnr_if.sv
rtl/bnr_csr.sv
rtl/bnr_lerp.sv
rtl/bnr_product.sv
rtl/bnr_divider.sv
rtl/bezier_newton_reparameterize.sv
tb/sv/bnr_step_checker.sv
tb/sv/tb_top.sv
